/* src/ricc_pkg.sv */
`default_nettype none

package ricc_pkg;

    localparam int unsigned LANES      = 4;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned WORD_W     = LANES * BYTE_W;
    localparam int unsigned CRC_W      = 16;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    // trailer word kinds, carried on the master tuser
    localparam logic [1:0] SLOT_SUM = 2'd0;
    localparam logic [1:0] SLOT_LO  = 2'd1;
    localparam logic [1:0] SLOT_HI  = 2'd2;

    typedef struct packed {
        logic take;       // word accepted this cycle
        logic take_last;  // accepted word closes the run
        logic fin_move;   // closing stage hands over to the trailer
    } ricc_ctrl_t;

    // reflected CRC-16 update with one byte
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        logic [CRC_W-1:0] t;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        t = {{(CRC_W-BYTE_W){1'b0}}, c[BYTE_W-1:0]};
        for (int k = 0; k < BYTE_W; k++)
        begin
            t = (t >> 1) ^ (t[0] ? CRC_POLY : '0);
        end
        return {{(CRC_W-BYTE_W){1'b0}}, c[CRC_W-1:BYTE_W]} ^ t;
    endfunction

endpackage

`default_nettype wire

/* src/ricc_lane.sv */
`default_nettype none

module ricc_lane
    import ricc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ricc_ctrl_t        ctrl,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire logic [BYTE_W-1:0] neg_byte,
    output logic      [CRC_W-1:0]  crc_out
);

    logic [CRC_W-1:0] crc_reg;
    logic [CRC_W-1:0] crc_next;
    logic [CRC_W-1:0] crc_upd;
    logic [CRC_W-1:0] fin_crc_reg;
    logic [CRC_W-1:0] trl_crc_reg;

    assign crc_upd = crc_byte(crc_reg, data_byte);

    always_comb
    begin
        crc_next = crc_reg;
        if (ctrl.take)
        begin
            crc_next = ctrl.take_last ? '0 : crc_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= '0;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

    // hold the closing CRC, then fold in the negated sum byte
    always_ff @(posedge clk)
    begin
        if (ctrl.take && ctrl.take_last)
        begin
            fin_crc_reg <= crc_upd;
        end
        if (ctrl.fin_move)
        begin
            trl_crc_reg <= crc_byte(fin_crc_reg, neg_byte);
        end
    end

    assign crc_out = trl_crc_reg;

endmodule

`default_nettype wire

/* src/ricc_trailer.sv */
`default_nettype none

module ricc_trailer
    import ricc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic [WORD_W-1:0]      in_word,
    input  wire logic                   in_last,
    output logic                        in_ready,
    input  wire logic [LANES*CRC_W-1:0] lane_crc,
    output ricc_ctrl_t                  ctrl,
    output logic      [WORD_W-1:0]      neg_word,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic      [WORD_W-1:0]      out_word,
    output logic      [1:0]             out_slot,
    output logic                        out_last
);

    logic [WORD_W-1:0] sum_reg;
    logic [WORD_W-1:0] sum_next;
    logic [WORD_W-1:0] neg_reg;
    logic [WORD_W-1:0] trl_neg_reg;
    logic              fin_valid_reg;
    logic              fin_valid_next;
    logic              trl_valid_reg;
    logic              trl_valid_next;
    logic [1:0]        slot_reg;
    logic [1:0]        slot_next;
    logic              take;
    logic              trl_done;
    logic              fin_move;
    logic [WORD_W-1:0] lo_word;
    logic [WORD_W-1:0] hi_word;

    assign trl_done = trl_valid_reg && out_ready && (slot_reg == SLOT_HI);
    assign fin_move = fin_valid_reg && (!trl_valid_reg || trl_done);
    assign in_ready = !fin_valid_reg || fin_move;
    assign take     = in_valid && in_ready;

    assign ctrl.take      = take;
    assign ctrl.take_last = in_last;
    assign ctrl.fin_move  = fin_move;
    assign neg_word       = neg_reg;

    always_comb
    begin
        sum_next       = sum_reg;
        fin_valid_next = fin_valid_reg;
        trl_valid_next = trl_valid_reg;
        slot_next      = slot_reg;
        if (take)
        begin
            sum_next = in_last ? '0 : sum_reg + in_word;
        end
        if (fin_move)
        begin
            fin_valid_next = 1'b0;
        end
        if (take && in_last)
        begin
            fin_valid_next = 1'b1;
        end
        if (trl_valid_reg && out_ready)
        begin
            case (slot_reg)
                SLOT_SUM: slot_next = SLOT_LO;
                SLOT_LO:  slot_next = SLOT_HI;
                default:
                begin
                    slot_next      = SLOT_SUM;
                    trl_valid_next = 1'b0;
                end
            endcase
        end
        if (fin_move)
        begin
            trl_valid_next = 1'b1;
            slot_next      = SLOT_SUM;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            fin_valid_reg <= 1'b0;
            trl_valid_reg <= 1'b0;
            slot_reg      <= SLOT_SUM;
        end
        else
        begin
            sum_reg       <= sum_next;
            fin_valid_reg <= fin_valid_next;
            trl_valid_reg <= trl_valid_next;
            slot_reg      <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_last)
        begin
            neg_reg <= '0 - sum_reg - in_word;
        end
        if (fin_move)
        begin
            trl_neg_reg <= neg_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            lo_word[i*BYTE_W +: BYTE_W] = lane_crc[i*CRC_W +: BYTE_W];
            hi_word[i*BYTE_W +: BYTE_W] = lane_crc[i*CRC_W + BYTE_W +: BYTE_W];
        end
    end

    always_comb
    begin
        case (slot_reg)
            SLOT_SUM: out_word = trl_neg_reg;
            SLOT_LO:  out_word = lo_word;
            default:  out_word = hi_word;
        endcase
    end

    assign out_valid = trl_valid_reg;
    assign out_slot  = slot_reg;
    assign out_last  = (slot_reg == SLOT_HI);

    a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        take && in_last |=> sum_reg == '0)
        else $error("sum not cleared after closing word");

    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid_reg && !fin_move |=> fin_valid_reg && $stable(neg_reg))
        else $error("closing stage lost while trailer busy");

    a_trl_start: assert property (@(posedge clk) disable iff (!rst_n)
        fin_move |=> trl_valid_reg && slot_reg == SLOT_SUM)
        else $error("trailer did not start with checksum word");

    a_no_bad_slot: assert property (@(posedge clk) disable iff (!rst_n)
        trl_valid_reg |-> slot_reg == SLOT_SUM || slot_reg == SLOT_LO
                          || slot_reg == SLOT_HI)
        else $error("trailer slot out of sequence");

endmodule

`default_nettype wire

/* src/rom_image_checksum_crc_engine.sv */
// Image checksum and CRC engine.
// Slave stream: one 32-bit image word per beat on s_axis_tdata (byte 0 in
// bits 7:0); s_axis_tlast marks the last word before the trailer.
// Master stream: three trailer words per run, in order: negated additive
// sum, CRC low bytes of lanes 0..3, CRC high bytes of lanes 0..3.
// m_axis_tuser gives the slot (0, 1, 2), m_axis_tlast marks the third word.
// Throughput: one input word per cycle, set by the four byte lanes each
// doing one CRC byte update per cycle. Each run drains three output beats,
// so runs shorter than three words stall the slave side while the trailer
// register is occupied.
// Path: the closing stage loads at the edge that accepts the closing word,
// and the trailer register loads from it once the trailer is free; the
// first trailer word is driven from the trailer register.
// Reset clears the sum, the lane CRCs and all valid flags; no pass is needed.
// When the receiver stalls, the trailer word holds; one more closing word
// waits in the closing stage, then s_axis_tready drops.
`default_nettype none

module rom_image_checksum_crc_engine
    import ricc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [WORD_W-1:0] s_axis_tdata,   // rom_word
    input  wire logic              s_axis_tlast,   // final_word
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [WORD_W-1:0] m_axis_tdata,   // patch_word
    output logic      [1:0]        m_axis_tuser,   // patch_slot
    output logic                   m_axis_tlast    // run_done
);

    ricc_ctrl_t               ctrl;
    logic [WORD_W-1:0]        neg_word;
    logic [LANES*CRC_W-1:0]   lane_crc;

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        ricc_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .data_byte (s_axis_tdata[i*BYTE_W +: BYTE_W]),
            .neg_byte  (neg_word[i*BYTE_W +: BYTE_W]),
            .crc_out   (lane_crc[i*CRC_W +: CRC_W])
        );
    end

    ricc_trailer u_trailer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_word   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .lane_crc  (lane_crc),
        .ctrl      (ctrl),
        .neg_word  (neg_word),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (m_axis_tdata),
        .out_slot  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire
